### rtl/tmtq_pkg.sv
package tmtq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 64;

	localparam logic [31:0] MAX_BUFFER_BYTES_RST = 32'd2097152;
	localparam logic [9:0]  REPORT_PERIOD_RST    = 10'd10;
	localparam logic [15:0] USER_ID_RST          = 16'd0;
	localparam logic [5:0]  CHANNEL_ID_RST       = 6'd0;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BUFFER_BYTES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_PERIOD    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_USER_ID          = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ID       = 2'd3;

	localparam logic [1:0] KIND_SDU_ARRIVAL = 2'd0;
	localparam logic [1:0] KIND_TX_OPP      = 2'd1;
	localparam logic [1:0] KIND_TICK        = 2'd2;

	localparam logic RESULT_BSR = 1'b0;
	localparam logic RESULT_PDU = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sdu_bytes;
		logic [15:0] sdu_tag;
		logic [31:0] grant_bytes;
		logic [2:0]  layer_in;
		logic [3:0]  harq_in;
		logic [7:0]  carrier_in;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] queued_bytes;
		logic [31:0] hol_delay_ms;
		logic        dropped;
		logic [15:0] pdu_bytes;
		logic [15:0] pdu_tag;
		logic [2:0]  layer_out;
		logic [3:0]  harq_out;
		logic [7:0]  carrier_out;
		logic [15:0] rnti_out;
		logic [5:0]  lcid_out;
	} out_word_t;

	typedef struct packed {
		logic [15:0] size;
		logic [15:0] tag;
		logic [31:0] arrival;
	} entry_t;

endpackage

### rtl/transparent_mode_tx_queue.sv
// Transmit queue for transparent-mode SDUs. It takes one input word per clock cycle and
// returns its result, if any, from a result register. The head-of-line descriptor is always
// held in a register, either a registered read of the descriptor memory or a bypass register
// for a descriptor just written to the head slot. A result that is not taken moves to a
// one-word skid register, and the input stalls only while that skid word is occupied. After
// reset the block accepts words at once; the descriptor memory needs no clearing pass.
// Configuration writes are taken in every cycle.
module transparent_mode_tx_queue #(
	parameter int unsigned QUEUE_DEPTH = tmtq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tmtq_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tmtq_pkg::out_word_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmtq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);
	import tmtq_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [31:0] max_bytes_q;
	logic [9:0]  period_q;
	logic [15:0] user_id_q;
	logic [5:0]  channel_id_q;

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      bytes_q, bytes_d;
	logic [31:0]      clock_q, clock_d;
	logic [9:0]       timer_q, timer_d;
	logic             armed_q, armed_d;

	entry_t           mem [QUEUE_DEPTH];
	entry_t           mem_rd_q;
	entry_t           byp_data_q;
	logic             byp_q;
	entry_t           head_entry;
	entry_t           wr_entry;
	logic             wr_en;

	logic             accept;
	logic             res_valid;
	out_word_t        res;
	out_word_t        skid_q;
	logic             skid_valid_q;

	logic [32:0]      sum;
	logic [9:0]       period_eff;
	logic [31:0]      clock_inc;
	logic             full;
	logic [PTR_W-1:0] head_inc, tail_inc;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !skid_valid_q;
	assign accept     = in_valid && in_ready;
	assign head_entry = byp_q ? byp_data_q : mem_rd_q;

	assign sum        = {1'b0, bytes_q} + {17'd0, in_data.sdu_bytes};
	assign period_eff = (period_q == 10'd0) ? 10'd1 : period_q;
	assign clock_inc  = clock_q + 32'd1;
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_inc   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	assign wr_entry.size    = in_data.sdu_bytes;
	assign wr_entry.tag     = in_data.sdu_tag;
	assign wr_entry.arrival = clock_q;

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		bytes_d   = bytes_q;
		clock_d   = clock_q;
		timer_d   = timer_q;
		armed_d   = armed_q;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		res          = '0;
		res.rnti_out = user_id_q;
		res.lcid_out = channel_id_q;
		if (accept) begin
			unique case (in_data.kind)
				KIND_SDU_ARRIVAL: begin
					res_valid       = 1'b1;
					res.result_kind = RESULT_BSR;
					armed_d         = 1'b0;
					timer_d         = '0;
					if (sum <= {1'b0, max_bytes_q} && !full) begin
						wr_en            = 1'b1;
						tail_d           = tail_inc;
						count_d          = count_q + CNT_W'(1);
						bytes_d          = sum[31:0];
						res.queued_bytes = sum[31:0];
						if (count_q != '0) begin
							res.hol_delay_ms = clock_q - head_entry.arrival;
						end
					end else begin
						res.dropped = 1'b1;
						if (count_q != '0) begin
							res.queued_bytes = bytes_q;
							res.hol_delay_ms = clock_q - head_entry.arrival;
						end
					end
				end
				KIND_TX_OPP: begin
					if (count_q != '0 && in_data.grant_bytes >= {16'd0, head_entry.size}) begin
						res_valid       = 1'b1;
						res.result_kind = RESULT_PDU;
						res.pdu_bytes   = head_entry.size;
						res.pdu_tag     = head_entry.tag;
						res.layer_out   = in_data.layer_in;
						res.harq_out    = in_data.harq_in;
						res.carrier_out = in_data.carrier_in;
						head_d          = head_inc;
						count_d         = count_q - CNT_W'(1);
						bytes_d         = bytes_q - {16'd0, head_entry.size};
						if (count_q != CNT_W'(1)) begin
							timer_d = period_eff;
							armed_d = 1'b1;
						end
					end
				end
				KIND_TICK: begin
					clock_d = clock_inc;
					if (armed_q) begin
						if (timer_q > 10'd1) begin
							timer_d = timer_q - 10'd1;
						end else begin
							timer_d = '0;
							armed_d = 1'b0;
							if (count_q != '0) begin
								res_valid        = 1'b1;
								res.result_kind  = RESULT_BSR;
								res.queued_bytes = bytes_q;
								res.hol_delay_ms = clock_inc - head_entry.arrival;
								timer_d          = period_eff;
								armed_d          = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_entry;
		end
		mem_rd_q <= mem[head_d];
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q   <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
			clock_q <= '0;
			timer_q <= '0;
			armed_q <= 1'b0;
		end else begin
			byp_q   <= wr_en && (tail_q == head_d);
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			bytes_q <= bytes_d;
			clock_q <= clock_d;
			timer_q <= timer_d;
			armed_q <= armed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q  <= MAX_BUFFER_BYTES_RST;
			period_q     <= REPORT_PERIOD_RST;
			user_id_q    <= USER_ID_RST;
			channel_id_q <= CHANNEL_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_BUFFER_BYTES: max_bytes_q  <= cfg_data;
				CFG_REPORT_PERIOD:    period_q     <= cfg_data[9:0];
				CFG_USER_ID:          user_id_q    <= cfg_data[15:0];
				CFG_CHANNEL_ID:       channel_id_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_valid_q) begin
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			out_data <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule
